/* src/pvs_pkg.sv */
// Shared constants, opcodes and controller/datapath interface types of the voxel store.
package pvs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COORD_W       = 4;
  localparam int CELL_AW       = 3 * COORD_W;
  localparam int CELL_COUNT    = 1 << CELL_AW;
  localparam int NZ_W          = CELL_AW + 1;
  localparam int ID_W          = 32;
  localparam int SCAN_W        = COORD_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_TOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic load;       // latch the accepted word, clear per-op result state
    logic sweep;      // write zero to the next cell of the clearing pass
    logic clr_apply;  // reset palette and nonzero count
    logic cell_rd;    // read the addressed cell
    logic pal_rd;     // read the palette at the cell's index
    logic pal_latch;  // capture the read identifier
    logic srch_step;  // advance the palette search
    logic wr_apply;   // commit a write
    logic scan_step;  // advance the column scan
    logic out_load;   // move results into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic srch_done;
    logic scan_done;
    logic out_busy;
  } dp_sts_t;

endpackage

/* src/pvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pvs_ctrl.sv */
// Controller state machine that sequences each operation of the voxel store.
module pvs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_opcode,
  input  pvs_pkg::dp_sts_t  sts,
  output pvs_pkg::dp_cmd_t  cmd
);
  import pvs_pkg::*;

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_CLEAR  = 10'b00_0000_0100,
    S_CELL   = 10'b00_0000_1000,
    S_PAL    = 10'b00_0001_0000,
    S_PALW   = 10'b00_0010_0000,
    S_SEARCH = 10'b00_0100_0000,
    S_WRITE  = 10'b00_1000_0000,
    S_TOP    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  op_t    in_op;

  assign in_op     = op_t'(in_opcode);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          op_nxt   = in_op;
          case (in_op)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_READ:  state_nxt = S_CELL;
            OP_WRITE: state_nxt = S_CELL;
            OP_TOP:   state_nxt = S_TOP;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep     = 1'b1;
        cmd.clr_apply = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CELL: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = (op_r == OP_READ) ? S_PAL : S_SEARCH;
      end
      S_PAL: begin
        cmd.pal_rd = 1'b1;
        state_nxt  = S_PALW;
      end
      S_PALW: begin
        cmd.pal_latch = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_apply = 1'b1;
        state_nxt    = S_DONE;
      end
      S_TOP: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      op_r    <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

/* src/pvs_dpath.sv */
// Datapath of the voxel store: cell and palette memories, counters and result registers.
module pvs_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pvs_pkg::dp_cmd_t                    cmd,
  output pvs_pkg::dp_sts_t                    sts,
  input  logic [pvs_pkg::COORD_W-1:0]         in_x,
  input  logic [pvs_pkg::COORD_W-1:0]         in_y,
  input  logic [pvs_pkg::COORD_W-1:0]         in_z,
  input  logic signed [pvs_pkg::ID_W-1:0]     in_id,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic signed [pvs_pkg::ID_W-1:0]     out_read_id,
  output logic [pvs_pkg::COORD_W-1:0]         out_top_y,
  output logic                                out_top_found,
  output logic                                out_all_empty,
  output logic                                out_status
);
  import pvs_pkg::*;

  // latched word
  logic [CELL_AW-1:0] addr_r;
  logic [ID_W-1:0]    id_r;

  // persistent store state
  logic [ID_W-1:0]    entry0_r;
  logic [CNT_W-1:0]   count_r;
  logic [NZ_W-1:0]    nz_r;
  logic [CELL_AW-1:0] sweep_r;

  // search and scan state
  logic [CNT_W-1:0]   srch_i_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic [SCAN_W-1:0]  scan_r;
  logic               scan_vld_r;
  logic [COORD_W-1:0] scan_y_r;

  // per-op results
  logic [ID_W-1:0]    read_id_r;
  logic [COORD_W-1:0] top_y_r;
  logic               top_found_r;
  logic               status_r;

  // output register
  logic               out_valid_r;
  logic [ID_W-1:0]    o_read_id_r;
  logic [COORD_W-1:0] o_top_y_r;
  logic               o_top_found_r;
  logic               o_all_empty_r;
  logic               o_status_r;

  // memory ports
  logic               cell_we, cell_re;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  logic [IDX_W-1:0]   cell_wdata, cell_rdata;
  logic               pal_we, pal_re;
  logic [IDX_W-1:0]   pal_raddr;
  logic [ID_W-1:0]    pal_rdata;

  logic               srch_issue, scan_issue, hit_now, full;
  logic [ID_W-1:0]    cmp_data;
  logic [IDX_W-1:0]   wr_idx;

  assign srch_issue = (srch_i_r < count_r);
  assign scan_issue = ~scan_r[SCAN_W-1];
  assign cmp_data   = (cmp_idx_r == '0) ? entry0_r : pal_rdata;
  assign hit_now    = cmp_vld_r && (cmp_data == id_r);
  assign full       = !found_r && (count_r == CNT_W'(PALETTE_DEPTH));
  assign wr_idx     = found_r ? found_idx_r : count_r[IDX_W-1:0];

  assign cell_we    = cmd.sweep | (cmd.wr_apply & ~full);
  assign cell_waddr = cmd.sweep ? sweep_r : addr_r;
  assign cell_wdata = cmd.sweep ? '0 : wr_idx;
  assign cell_re    = cmd.cell_rd | (cmd.scan_step & scan_issue);
  assign cell_raddr = cmd.scan_step ? {addr_r[CELL_AW-1:COORD_W], scan_r[COORD_W-1:0]}
                                    : addr_r;

  assign pal_we    = cmd.wr_apply & ~found_r & ~full;
  assign pal_re    = cmd.pal_rd | (cmd.srch_step & srch_issue);
  assign pal_raddr = cmd.pal_rd ? cell_rdata : srch_i_r[IDX_W-1:0];

  pvs_ram #(.WIDTH(IDX_W), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  pvs_ram #(.WIDTH(ID_W), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (id_r),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  assign sts.sweep_last = &sweep_r;
  assign sts.srch_done  = hit_now || (!cmp_vld_r && !srch_issue);
  assign sts.scan_done  = !scan_issue && !scan_vld_r;
  assign sts.out_busy   = out_valid_r && !out_tready;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r      <= {in_x, in_z, in_y};
      id_r        <= in_id;
      read_id_r   <= '0;
      top_y_r     <= '0;
      top_found_r <= 1'b0;
      status_r    <= 1'b0;
    end
    if (cmd.pal_latch) begin
      read_id_r <= (cell_rdata == '0) ? entry0_r : pal_rdata;
    end
    if (cmd.srch_step && srch_issue) begin
      cmp_idx_r <= srch_i_r[IDX_W-1:0];
    end
    if (cmd.srch_step && hit_now && !found_r) begin
      found_idx_r <= cmp_idx_r;
    end
    if (cmd.wr_apply && full) begin
      status_r <= 1'b1;
    end
    if (cmd.scan_step && scan_issue) begin
      scan_y_r <= scan_r[COORD_W-1:0];
    end
    if (cmd.scan_step && scan_vld_r && (cell_rdata != '0)) begin
      top_y_r     <= scan_y_r;
      top_found_r <= 1'b1;
    end
    if (cmd.out_load) begin
      o_read_id_r   <= read_id_r;
      o_top_y_r     <= top_y_r;
      o_top_found_r <= top_found_r;
      o_all_empty_r <= (nz_r == '0);
      o_status_r    <= status_r;
    end
  end

  // control and store state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry0_r    <= '0;
      count_r     <= CNT_W'(1);
      nz_r        <= '0;
      sweep_r     <= '0;
      srch_i_r    <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      scan_r      <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.clr_apply) begin
        entry0_r <= id_r;
        count_r  <= CNT_W'(1);
        nz_r     <= '0;
      end
      if (cmd.load) begin
        srch_i_r   <= '0;
        cmp_vld_r  <= 1'b0;
        found_r    <= 1'b0;
        scan_r     <= '0;
        scan_vld_r <= 1'b0;
      end
      if (cmd.srch_step) begin
        if (srch_issue) begin
          srch_i_r <= srch_i_r + 1'b1;
        end
        cmp_vld_r <= srch_issue;
        if (hit_now) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.wr_apply && !full) begin
        if (!found_r) begin
          count_r <= count_r + 1'b1;
        end
        if ((cell_rdata == '0) && (wr_idx != '0)) begin
          nz_r <= nz_r + 1'b1;
        end else if ((cell_rdata != '0) && (wr_idx == '0)) begin
          nz_r <= nz_r - 1'b1;
        end
      end
      if (cmd.scan_step) begin
        if (scan_issue) begin
          scan_r <= scan_r + 1'b1;
        end
        scan_vld_r <= scan_issue;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_read_id   = o_read_id_r;
  assign out_top_y     = o_top_y_r;
  assign out_top_found = o_top_found_r;
  assign out_all_empty = o_all_empty_r;
  assign out_status    = o_status_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(PALETTE_DEPTH)))
    else $error("palette count out of range");

  a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
    nz_r <= NZ_W'(CELL_COUNT))
    else $error("nonzero cell count exceeds cell count");
`endif

endmodule

/* src/palette_voxel_store_unit.sv */
// Top level of the palette-compressed 16x16x16 voxel store.
// A read reads the addressed cell, then the palette at the cell's index; a write reads the
// cell, searches the palette (one palette entry per cycle), then commits; top of column scans
// the column's cells; clear zeroes the cell memory (one cell per cycle). One word is in flight
// at a time; a finished result waits in the output register while the next word is accepted.
// Reset is synchronous, active low; afterwards a pass zeroes the cell memory, and in_tready
// stays low until it ends.
module palette_voxel_store_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cell_x[3:0], cell_y[7:4], cell_z[11:8], block_id[43:12]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_id[31:0], top_y[35:32], top_found[36],
                                  // all_empty[37], status[38]
);
  import pvs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic signed [ID_W-1:0] read_id;
  logic [COORD_W-1:0]     top_y;
  logic                   top_found;
  logic                   all_empty;
  logic                   status;

  // sequence each word through cell read, palette lookup/search, column scan or clearing sweep
  pvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold memories, counters and the output register
  pvs_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_x          (in_tdata[3:0]),
    .in_y          (in_tdata[7:4]),
    .in_z          (in_tdata[11:8]),
    .in_id         (in_tdata[43:12]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_read_id   (read_id),
    .out_top_y     (top_y),
    .out_top_found (top_found),
    .out_all_empty (all_empty),
    .out_status    (status)
  );

  // pack results, lowest field first, pad to whole bytes
  assign out_tdata = {1'b0, status, all_empty, top_found, top_y, read_id};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while one is in flight");

  a_top_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[36]) |-> (out_tdata[35:32] == 4'd0))
    else $error("top_y nonzero without top_found");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[38]) |-> (!out_tdata[36] && (out_tdata[31:0] == 32'd0)))
    else $error("refused write carries read or top data");
`endif

endmodule

/* dv/palette_voxel_store_unit_tb.sv */
// Self-checking stream testbench for the palette voxel store, with its own behavioral predictor.
module palette_voxel_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvs_pkg::*;

  // One command word as the sender sees it, before packing onto in_tdata/in_tuser.
  typedef struct packed {
    op_t         op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    logic [31:0] id;
  } voxel_cmd_t;

  // Field order matches out_tdata[38:0], lowest field last.
  typedef struct packed {
    logic        status;
    logic        all_empty;
    logic        top_found;
    logic [3:0]  top_y;
    logic [31:0] read_id;
  } voxel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // cell_x[3:0], cell_y[7:4], cell_z[11:8], block_id[43:12]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // read_id[31:0], top_y[35:32], top_found[36],
                                // all_empty[37], status[38]

  palette_voxel_store_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted contents of the store.
  logic [IDX_W-1:0] cell_idx [CELL_COUNT];
  logic [ID_W-1:0]  pal_ent  [PALETTE_DEPTH];
  int               pal_cnt;
  int               nz_cnt;

  voxel_cmd_t    cmd_q[$];      // words still to be offered
  voxel_result_t result_q[$];   // results owed by the block, oldest first

  int accepted_cnt = 0;
  int offered_cnt  = 0;
  int err_cnt      = 0;
  int send_idle    = 20;        // percent of cycles the sender holds off
  int recv_idle    = 86;        // percent of cycles the receiver holds off
  int hold_req     = 0;         // bump to start one long receiver hold-off
  int hold_seen    = 0;
  int hold_left    = 0;

  logic [31:0] id_pool [8];     // small set of identifiers so writes hit the palette
  logic [3:0]  focus_x, focus_z;

  // Apply one word to the predicted store and return the result it owes.
  function automatic voxel_result_t predict_voxel_op(op_t op, logic [3:0] x, logic [3:0] y,
                                                     logic [3:0] z, logic [31:0] id);
    voxel_result_t r;
    int            addr;
    int            i;
    int            yy;
    r = '0;
    addr = {x, z, y};
    case (op)
      OP_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) cell_idx[i] = '0;
        pal_ent[0] = id;
        pal_cnt = 1;
        nz_cnt = 0;
      end
      OP_READ: begin
        r.read_id = pal_ent[cell_idx[addr]];
      end
      OP_WRITE: begin
        // lowest matching entry wins; append only when absent
        i = 0;
        while (i < pal_cnt && pal_ent[i] != id) i++;
        if (i == pal_cnt) begin
          if (pal_cnt < PALETTE_DEPTH) begin
            pal_ent[i] = id;
            pal_cnt++;
          end else begin
            r.status = 1'b1;
          end
        end
        if (!r.status) begin
          if (cell_idx[addr] == 0 && i != 0) nz_cnt++;
          else if (cell_idx[addr] != 0 && i == 0) nz_cnt--;
          cell_idx[addr] = IDX_W'(i);
        end
      end
      default: begin
        for (yy = 15; yy >= 0; yy--) begin
          if (!r.top_found && cell_idx[{x, z, 4'(yy)}] != 0) begin
            r.top_found = 1'b1;
            r.top_y = 4'(yy);
          end
        end
      end
    endcase
    r.all_empty = (nz_cnt == 0);
    return r;
  endfunction

  function automatic logic [31:0] rand_id();
    int r;
    r = $urandom_range(99);
    if (r < 65) return id_pool[$urandom_range(7)];
    if (r < 90) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic push_cmd(op_t op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                          logic [31:0] id);
    voxel_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.z = z;
    c.id = id;
    cmd_q.push_back(c);
  endtask

  // Refresh the identifier pool around the palette's new entry zero and pick a hot column.
  task automatic new_pool(logic [31:0] first_id);
    int i;
    id_pool[0] = '0;
    id_pool[1] = first_id;
    for (i = 2; i < 8; i++) id_pool[i] = $urandom;
    focus_x = 4'($urandom);
    focus_z = 4'($urandom);
  endtask

  task automatic gen_random(int n);
    int          r;
    logic [3:0]  x, y, z;
    logic [31:0] c;
    repeat (n) begin
      r = $urandom_range(99);
      x = 4'($urandom);
      y = 4'($urandom);
      z = 4'($urandom);
      // half the traffic lands in one column so top and overwrite see real history
      if ($urandom_range(1)) begin
        x = focus_x;
        z = focus_z;
      end
      if (r < 2) begin
        c = rand_id();
        push_cmd(OP_CLEAR, x, y, z, c);
        new_pool(c);
      end else if (r < 32) begin
        push_cmd(OP_READ, x, y, z, rand_id());
      end else if (r < 75) begin
        push_cmd(OP_WRITE, x, y, z, rand_id());
      end else begin
        push_cmd(OP_TOP, x, y, z, rand_id());
      end
    end
  endtask

  // Fill the palette to the last entry, then push past it so new identifiers get refused.
  task automatic gen_fill();
    logic [31:0] base;
    int          k;
    base = $urandom;
    push_cmd(OP_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom), base);
    new_pool(base);
    for (k = 1; k <= 270; k++) begin
      push_cmd(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom), base + k);
      if (k % 16 == 0) push_cmd(OP_TOP, focus_x, 4'($urandom), focus_z, base);
    end
    // mix of identifiers already held and ones that no longer fit
    for (k = 1; k < 8; k++) id_pool[k] = base + $urandom_range(300);
    gen_random(20);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || accepted_cnt != offered_cnt || result_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      err_cnt++;
    end
  endtask

  // Sender: at the falling edge, hold the current word until taken, then offer the next
  // word or stay idle.
  always @(negedge clk) begin : drive_in
    voxel_cmd_t c;
    if (rst_n && (!in_tvalid || accepted_cnt == offered_cnt)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        c = cmd_q.pop_front();
        in_tdata  <= {4'b0, c.id, c.z, c.y, c.x};
        in_tuser  <= c.op;
        in_tvalid <= 1'b1;
        offered_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Every word the block takes is run through the predictor right away.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready === 1'b1) begin
      result_q.push_back(predict_voxel_op(op_t'(in_tuser), in_tdata[3:0], in_tdata[7:4],
                                          in_tdata[11:8], in_tdata[43:12]));
      accepted_cnt++;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the block
  // backs up and drops in_tready while the sender keeps offering.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each taken result word with the oldest prediction, field by field.
  always @(posedge clk) begin : watch_out
    voxel_result_t want;
    voxel_result_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = voxel_result_t'(out_tdata[38:0]);
      if (result_q.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", out_tdata);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("read_id",   want.read_id,   got.read_id);
        check_field("top_y",     want.top_y,     got.top_y);
        check_field("top_found", want.top_found, got.top_found);
        check_field("all_empty", want.all_empty, got.all_empty);
        check_field("status",    want.status,    got.status);
      end
    end
  end

  initial begin : stimulus
    int mark;
    // reset state is the same as a clear to identifier zero
    void'(predict_voxel_op(OP_CLEAR, 4'd0, 4'd0, 4'd0, 32'd0));
    new_pool(32'd0);
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty store, coordinate extremes, identifier extremes, writes that
    // map back to entry zero, clear to a nonzero identifier, top at both ends.
    push_cmd(OP_READ,  4'd0,  4'd0,  4'd0,  32'd0);
    push_cmd(OP_TOP,   4'd15, 4'd0,  4'd15, 32'd0);
    push_cmd(OP_WRITE, 4'd15, 4'd15, 4'd15, 32'h7fff_ffff);
    push_cmd(OP_READ,  4'd15, 4'd15, 4'd15, 32'd0);
    push_cmd(OP_TOP,   4'd15, 4'd3,  4'd15, 32'd0);
    push_cmd(OP_WRITE, 4'd0,  4'd0,  4'd0,  32'h8000_0000);
    push_cmd(OP_WRITE, 4'd15, 4'd15, 4'd15, 32'd0);
    push_cmd(OP_TOP,   4'd15, 4'd0,  4'd15, 32'd0);
    push_cmd(OP_READ,  4'd0,  4'd0,  4'd0,  32'd0);
    push_cmd(OP_WRITE, 4'd0,  4'd0,  4'd0,  32'd0);
    push_cmd(OP_CLEAR, 4'd5,  4'd5,  4'd5,  32'hdead_beef);
    push_cmd(OP_READ,  4'd9,  4'd4,  4'd2,  32'd0);
    push_cmd(OP_WRITE, 4'd3,  4'd0,  4'd12, 32'hdead_beef);
    push_cmd(OP_WRITE, 4'd3,  4'd0,  4'd12, 32'hffff_ffff);
    push_cmd(OP_TOP,   4'd3,  4'd9,  4'd12, 32'd0);
    push_cmd(OP_WRITE, 4'd3,  4'd7,  4'd12, 32'd1);
    push_cmd(OP_TOP,   4'd3,  4'd0,  4'd12, 32'd0);
    push_cmd(OP_READ,  4'd3,  4'd7,  4'd12, 32'd0);
    push_cmd(OP_WRITE, 4'd3,  4'd7,  4'd12, 32'hffff_ffff);
    push_cmd(OP_READ,  4'd3,  4'd7,  4'd12, 32'd0);
    push_cmd(OP_CLEAR, 4'd0,  4'd0,  4'd0,  32'd0);
    push_cmd(OP_READ,  4'd3,  4'd0,  4'd12, 32'd0);
    // the sender stays quiet until every directed result is back
    wait_drained();

    // slow receiver
    send_idle = 20;
    recv_idle = 86;
    gen_random(300);
    gen_fill();
    gen_random(40);
    wait_drained();

    // slow sender
    send_idle = 86;
    recv_idle = 20;
    gen_random(300);
    gen_fill();
    gen_random(40);
    wait_drained();

    // full rate, with one long receiver stall once traffic is flowing
    send_idle = 0;
    recv_idle = 0;
    mark = accepted_cnt;
    gen_random(620);
    while (accepted_cnt < mark + 40) @(posedge clk);
    hold_req++;
    wait_drained();

    // let any stray result show up before the verdict
    repeat (300) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
